@@ hdl/mic_pkg.sv @@
// ----------------------------------------------------------------------------
// mic_pkg
// Shared widths, constants and register codes of the magnetometer iron
// correction block.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam int BYTE_W    = 8;
    localparam int AXIS_W    = 16;
    localparam int CORR_W    = 27;
    localparam int COEF_W    = 18;
    localparam int OFFS_W    = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Scaled value width (Q.8) and offset-free value width
    localparam int S_W      = 24;
    localparam int T_W      = 25;
    localparam int SCALE_SH = 8;
    localparam int COEF_SH  = 16;

    // Bits of the multiplier consumed per cycle
    localparam int DIGIT_W = 2;

    // Q0.16 gain from raw counts to Q.8 units
    localparam logic [AXIS_W-1:0] SCALE_Q16 = 16'd9830;

    localparam logic [CFG_W-1:0] HARD_IRON_RST = 48'd1825340653905;
    localparam logic signed [COEF_W-1:0] COEF_XX_RST = 18'sd64249;
    localparam logic signed [COEF_W-1:0] COEF_XY_RST = -18'sd691;
    localparam logic signed [COEF_W-1:0] COEF_XZ_RST = 18'sd495;
    localparam logic signed [COEF_W-1:0] COEF_YY_RST = 18'sd62302;
    localparam logic signed [COEF_W-1:0] COEF_YZ_RST = -18'sd2327;
    localparam logic signed [COEF_W-1:0] COEF_ZZ_RST = 18'sd70418;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HARD_IRON,
        REG_COEF_XX,
        REG_COEF_XY,
        REG_COEF_XZ,
        REG_COEF_YY,
        REG_COEF_YZ,
        REG_COEF_ZZ
    } t_reg_idx;

endpackage

@@ hdl/mic_in_if.sv @@
// ----------------------------------------------------------------------------
// mic_in_if
// Input channel: one raw magnetometer read with its bus error flag.
// ----------------------------------------------------------------------------
interface mic_in_if
    import mic_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] x_low_byte;
    logic [BYTE_W-1:0] x_high_byte;
    logic [BYTE_W-1:0] y_low_byte;
    logic [BYTE_W-1:0] y_high_byte;
    logic [BYTE_W-1:0] z_low_byte;
    logic [BYTE_W-1:0] z_high_byte;
    logic              read_error;

    modport source (
        output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte, read_error,
        input  ready
    );

    modport sink (
        input  valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte, read_error,
        output ready
    );
endinterface

@@ hdl/mic_out_if.sv @@
// ----------------------------------------------------------------------------
// mic_out_if
// Output channel: smoothed counts and calibrated field of one read.
// ----------------------------------------------------------------------------
interface mic_out_if
    import mic_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     sample_valid;
    logic signed [AXIS_W-1:0] smoothed_x;
    logic signed [AXIS_W-1:0] smoothed_y;
    logic signed [AXIS_W-1:0] smoothed_z;
    logic signed [CORR_W-1:0] corrected_x;
    logic signed [CORR_W-1:0] corrected_y;
    logic signed [CORR_W-1:0] corrected_z;

    modport source (
        output valid, sample_valid, smoothed_x, smoothed_y, smoothed_z,
               corrected_x, corrected_y, corrected_z,
        input  ready
    );

    modport sink (
        input  valid, sample_valid, smoothed_x, smoothed_y, smoothed_z,
               corrected_x, corrected_y, corrected_z,
        output ready
    );
endinterface

@@ hdl/mic_dot_serial.sv @@
// ----------------------------------------------------------------------------
// mic_dot_serial
// Digit-serial dot product: multiplier digits enter LSB first, one digit
// per cycle, into a right-shifting accumulator.
// ----------------------------------------------------------------------------
module mic_dot_serial
    import mic_pkg::*;
#(
    parameter int TERMS = 3,
    parameter int MW    = COEF_W,
    parameter int BW    = 26,
    parameter int DW    = DIGIT_W,
    localparam int AW   = MW + DW + $clog2(TERMS) + 2,
    localparam int PW   = AW + BW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [MW-1:0] i_mcand  [TERMS],
    input  logic signed [BW-1:0] i_mplier [TERMS],
    output logic                 o_done,
    output logic signed [PW-1:0] o_prod
);

    localparam int ND = BW / DW;
    localparam int CW = (ND > 1) ? $clog2(ND) : 1;

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [BW-1:0]        r_mp [TERMS];
    logic signed [AW-1:0] r_acc;
    logic [BW-1:0]        r_lo;

    logic                   w_last;
    logic signed [DW:0]     w_dig [TERMS];
    logic signed [MW+DW:0]  w_pp  [TERMS];
    logic signed [AW-1:0]   w_sum;
    logic signed [AW-1:0]   n_acc;
    logic [BW-1:0]          n_lo;

    always_comb begin
        w_last = (r_cnt == CW'(ND - 1));
        w_sum  = r_acc;
        for (int t = 0; t < TERMS; t++) begin
            // top digit carries the sign weight
            if (w_last) begin
                w_dig[t] = signed'({r_mp[t][DW-1], r_mp[t][DW-1:0]});
            end else begin
                w_dig[t] = signed'({1'b0, r_mp[t][DW-1:0]});
            end
            w_pp[t] = i_mcand[t] * w_dig[t];
            w_sum   = w_sum + AW'(w_pp[t]);
        end
        n_acc = w_sum >>> DW;
        n_lo  = {w_sum[DW-1:0], r_lo[BW-1:DW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_lo  <= '0;
            for (int t = 0; t < TERMS; t++) begin
                r_mp[t] <= i_mplier[t];
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_lo  <= n_lo;
            for (int t = 0; t < TERMS; t++) begin
                r_mp[t] <= r_mp[t] >> DW;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = signed'({r_acc, r_lo});

endmodule

@@ hdl/magnetometer_iron_correction.sv @@
// ----------------------------------------------------------------------------
// magnetometer_iron_correction
// Smooths a raw magnetometer read and applies hard- and soft-iron correction.
// ----------------------------------------------------------------------------
// Each good word passes through the scaling phase, the soft-iron matrix phase and the
//   write phase into the output register; a read-error word goes straight to the write phase.
// A new word is accepted only in the idle state, once the previous result is in the output register.
// A new word is taken while the previous result still waits at the output.
// Reset (synchronous, active low): averages cleared, calibration registers
//   loaded with their defaults, output emptied.
// ----------------------------------------------------------------------------
module magnetometer_iron_correction
    import mic_pkg::*;
#(
    parameter int P_DIGIT_W = DIGIT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mic_in_if.sink               i_sample,
    mic_out_if.source            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Multiplier widths rounded up to whole digits
    localparam int BW1   = ((AXIS_W + P_DIGIT_W - 1) / P_DIGIT_W) * P_DIGIT_W;
    localparam int BW2   = ((T_W + P_DIGIT_W - 1) / P_DIGIT_W) * P_DIGIT_W;
    localparam int MC1_W = AXIS_W + 1;
    localparam int P1_W  = MC1_W + P_DIGIT_W + 2 + BW1;
    localparam int P2_W  = COEF_W + P_DIGIT_W + $clog2(3) + 2 + BW2;
    localparam int SUM_W = AXIS_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_MATRIX,
        S_WRITE
    } t_state;

    t_state r_state;
    logic   r_err;
    logic   r_out_valid;
    logic   r_sv;
    logic signed [AXIS_W-1:0] r_sm   [3];
    logic signed [CORR_W-1:0] r_cr   [3];
    logic signed [AXIS_W-1:0] r_prev [3];

    // Calibration registers
    logic [CFG_W-1:0]         r_offs;
    logic signed [COEF_W-1:0] r_cxx, r_cxy, r_cxz, r_cyy, r_cyz, r_czz;

    logic w_in_acc;
    logic w_start1;
    logic signed [AXIS_W-1:0] w_raw  [3];
    logic signed [AXIS_W-1:0] w_yraw, w_zraw;
    logic signed [SUM_W-1:0]  w_sum  [3];
    logic signed [SUM_W-1:0]  w_adj  [3];
    logic signed [AXIS_W-1:0] n_prev [3];
    logic signed [MC1_W-1:0]  w_scale_mc [1];
    logic signed [BW1-1:0]    w_mp1  [3][1];
    logic signed [P1_W-1:0]   w_p1   [3];
    logic                     w_done1 [3];
    logic signed [S_W-1:0]    w_s    [3];
    logic signed [OFFS_W-1:0] w_off  [3];
    logic signed [T_W-1:0]    w_tv   [3];
    logic signed [BW2-1:0]    w_t    [3];
    logic signed [COEF_W-1:0] w_coef [3][3];
    logic signed [P2_W-1:0]   w_p2   [3];
    logic                     w_done2 [3];

    assign w_in_acc = i_sample.valid && i_sample.ready;
    assign w_start1 = w_in_acc && !i_sample.read_error;

    // Assemble the little-endian counts; Y and Z are flipped, -32768 wraps
    assign w_raw[0] = signed'({i_sample.x_high_byte, i_sample.x_low_byte});
    assign w_yraw   = signed'({i_sample.y_high_byte, i_sample.y_low_byte});
    assign w_zraw   = signed'({i_sample.z_high_byte, i_sample.z_low_byte});
    assign w_raw[1] = AXIS_W'(~w_yraw + AXIS_W'(1));
    assign w_raw[2] = AXIS_W'(~w_zraw + AXIS_W'(1));

    assign w_scale_mc[0] = signed'({1'b0, SCALE_Q16});

    assign w_coef[0][0] = r_cxx;
    assign w_coef[0][1] = r_cxy;
    assign w_coef[0][2] = r_cxz;
    assign w_coef[1][0] = r_cxy;
    assign w_coef[1][1] = r_cyy;
    assign w_coef[1][2] = r_cyz;
    assign w_coef[2][0] = r_cxz;
    assign w_coef[2][1] = r_cyz;
    assign w_coef[2][2] = r_czz;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        // Average with the kept value, truncating toward zero:
        // bias negative sums by one before the halving shift
        assign w_sum[a]  = SUM_W'(r_prev[a]) + SUM_W'(w_raw[a]);
        assign w_adj[a]  = w_sum[a] + SUM_W'({1'b0, w_sum[a][SUM_W-1]});
        assign n_prev[a] = w_adj[a][AXIS_W:1];
        assign w_mp1[a][0] = BW1'(n_prev[a]);

        // Scale to Q.8: floor of the product over 2^8
        mic_dot_serial #(
            .TERMS (1),
            .MW    (MC1_W),
            .BW    (BW1),
            .DW    (P_DIGIT_W)
        ) u_scale (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (w_start1),
            .i_mcand  (w_scale_mc),
            .i_mplier (w_mp1[a]),
            .o_done   (w_done1[a]),
            .o_prod   (w_p1[a])
        );

        // Remove the hard-iron offset
        assign w_s[a]   = w_p1[a][SCALE_SH +: S_W];
        assign w_off[a] = signed'(r_offs[a*OFFS_W +: OFFS_W]);
        assign w_tv[a]  = T_W'(w_s[a]) - T_W'(w_off[a]);
        assign w_t[a]   = BW2'(w_tv[a]);

        // One soft-iron matrix row per lane, floor over 2^16
        mic_dot_serial #(
            .TERMS (3),
            .MW    (COEF_W),
            .BW    (BW2),
            .DW    (P_DIGIT_W)
        ) u_row (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (w_done1[0]),
            .i_mcand  (w_coef[a]),
            .i_mplier (w_t),
            .o_done   (w_done2[a]),
            .o_prod   (w_p2[a])
        );
    end

    // Kept averages and calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= '0;
            end
            r_offs <= HARD_IRON_RST;
            r_cxx  <= COEF_XX_RST;
            r_cxy  <= COEF_XY_RST;
            r_cxz  <= COEF_XZ_RST;
            r_cyy  <= COEF_YY_RST;
            r_cyz  <= COEF_YZ_RST;
            r_czz  <= COEF_ZZ_RST;
        end else begin
            // advance the averages only on a good read
            if (w_start1) begin
                for (int a = 0; a < 3; a++) begin
                    r_prev[a] <= n_prev[a];
                end
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_HARD_IRON: r_offs <= i_cfg_data;
                    REG_COEF_XX:   r_cxx  <= signed'(i_cfg_data[COEF_W-1:0]);
                    REG_COEF_XY:   r_cxy  <= signed'(i_cfg_data[COEF_W-1:0]);
                    REG_COEF_XZ:   r_cxz  <= signed'(i_cfg_data[COEF_W-1:0]);
                    REG_COEF_YY:   r_cyy  <= signed'(i_cfg_data[COEF_W-1:0]);
                    REG_COEF_YZ:   r_cyz  <= signed'(i_cfg_data[COEF_W-1:0]);
                    REG_COEF_ZZ:   r_czz  <= signed'(i_cfg_data[COEF_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output word once taken, unless the write phase refills it
            if (r_out_valid && o_result.ready && r_state != S_WRITE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_err   <= i_sample.read_error;
                        r_state <= i_sample.read_error ? S_WRITE : S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (w_done1[0]) begin
                        r_state <= S_MATRIX;
                    end
                end
                S_MATRIX: begin
                    if (w_done2[0]) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    // hold the result until the output register is free
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_sv        <= !r_err;
                        for (int a = 0; a < 3; a++) begin
                            if (r_err) begin
                                r_sm[a] <= '0;
                                r_cr[a] <= '0;
                            end else begin
                                r_sm[a] <= r_prev[a];
                                r_cr[a] <= w_p2[a][COEF_SH +: CORR_W];
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_sample.ready        = (r_state == S_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.sample_valid = r_sv;
    assign o_result.smoothed_x   = r_sm[0];
    assign o_result.smoothed_y   = r_sm[1];
    assign o_result.smoothed_z   = r_sm[2];
    assign o_result.corrected_x  = r_cr[0];
    assign o_result.corrected_y  = r_cr[1];
    assign o_result.corrected_z  = r_cr[2];

    a_scale_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done1[0] |-> (w_done1[1] && w_done1[2]))
        else $error("scale lanes finished out of step");

    a_matrix_done_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done2[0] |-> (w_done2[1] && w_done2[2] && r_state == S_MATRIX))
        else $error("matrix lanes finished out of step or outside the matrix phase");

    a_prev_only_on_good_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_start1 |=> ($stable(r_prev[0]) && $stable(r_prev[1]) && $stable(r_prev[2])))
        else $error("kept average changed without a good read");

    a_out_load_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("output word loaded outside the write phase");

endmodule
